>>> hw/rtl/sroc_pkg.sv
// sroc_pkg: shared types and constants of the sliding rms onset detector
// holds the beat payload structs, register indexes and datapath widths
// no dependencies
package sroc_pkg;

   // ring and window sizing
   localparam int WINDOW_MAX  = 1024;
   localparam int PTR_BITS    = $clog2(WINDOW_MAX);
   localparam int WIN_BITS    = PTR_BITS + 1;
   localparam int SAMPLE_BITS = 16;

   // datapath widths
   localparam int SQ_BITS    = 2 * SAMPLE_BITS - 1;
   localparam int SUM_BITS   = SQ_BITS + PTR_BITS;
   localparam int RATIO_BITS = 24;
   localparam int PRE_BITS   = 16;
   localparam int IDX_BITS   = 32;
   localparam int BG_LO_BITS = RATIO_BITS;
   localparam int BG_HI_BITS = SUM_BITS - BG_LO_BITS;
   localparam int PROD_BITS  = SUM_BITS + RATIO_BITS;

   // configuration port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 24;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_POWER_RATIO   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PRE_ONSET     = 2'd2;

   // register reset values
   localparam logic [WIN_BITS-1:0]   WINDOW_LENGTH_RESET = 11'd441;
   localparam logic [RATIO_BITS-1:0] POWER_RATIO_RESET   = 24'd2560;
   localparam logic [PRE_BITS-1:0]   PRE_ONSET_RESET     = 16'd0;

   // input beat
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          last;
   } req_type;

   // result beat
   typedef struct packed {
      logic                found;
      logic [IDX_BITS-1:0] onset_index;
   } rsp_type;

endpackage

>>> hw/rtl/sliding_rms_onset_detector_core.sv
// sliding_rms_onset_detector_core: onset search over a sliding sum of squares
// depends on sroc_pkg for types and constants and on sroc_ram for the sample ring
//
// Usage
//   req_*  : one signed audio sample per beat, req_data.last on the final one
//            of a buffer. A sample is taken on each cycle with valid and ready.
//   rsp_*  : at most one beat per buffer. found=1 with the onset index (minus
//            the pre-onset count, clamped at zero) the first time the window
//            power beats background times ratio; found=0 and index 0 when the
//            buffer ends first or is no longer than the window.
//   csr_*  : write-only registers, written while the block is idle. The window
//            length is captured on the first sample of every buffer.
// Throughput is one sample per cycle while no blocked result stalls the pipeline;
// the loop that sets it is the running sum update, one add, compare and subtract
// per sample. A result passes stage 1, stage 2, stage 3 and the output register.
// Reset loads the register defaults and starts a fresh buffer. The ring needs
// no clearing: every entry is written during the background window before it
// is read.
// While a result beat waits in the output register, samples keep flowing; the
// pipeline stalls only when a second result reaches the last stage.
module sliding_rms_onset_detector_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  sroc_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output sroc_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_we,
   input  logic [sroc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [sroc_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   import sroc_pkg::*;

   // configuration
   logic [WIN_BITS-1:0]   win_len_ff;
   logic [RATIO_BITS-1:0] ratio_ff;
   logic [PRE_BITS-1:0]   pre_ff;

   // front state, updated at acceptance
   logic [IDX_BITS-1:0] count_ff, count_in;
   logic [PTR_BITS-1:0] ptr_ff, ptr_in;
   logic [WIN_BITS-1:0] win_ff, win_in;
   logic                fill_ff, fill_in;
   logic [WIN_BITS-1:0] win_eff;
   logic [WIN_BITS:0]   ptr_inc;
   logic                fill_end;
   logic                accept;
   logic                adv;

   // stage 1: sample registered, ring read under way
   logic                          s1_valid_ff;
   logic signed [SAMPLE_BITS-1:0] s1_sample_ff;
   logic                          s1_last_ff, s1_fill_ff, s1_fend_ff;
   logic [IDX_BITS-1:0]           s1_idx_ff;
   logic [SAMPLE_BITS-1:0]        ring_rdata;
   logic signed [2*SAMPLE_BITS-1:0] sq_full, osq_full;

   // stage 2: squares
   logic                s2_valid_ff;
   logic [SQ_BITS-1:0]  s2_sq_ff, s2_osq_ff;
   logic                s2_last_ff, s2_fill_ff, s2_fend_ff;
   logic [IDX_BITS-1:0] s2_idx_ff;

   // running sums
   logic [SUM_BITS-1:0] sum_ff, sum_in;
   logic [SUM_BITS-1:0] bg_ff, bg_in;
   logic [SUM_BITS:0]   acc;
   logic [SUM_BITS-1:0] sum_new;

   // stage 3: updated sum, compare against background times ratio
   logic                s3_valid_ff;
   logic [SUM_BITS-1:0] s3_sum_ff;
   logic                s3_last_ff, s3_fill_ff;
   logic [IDX_BITS-1:0] s3_idx_ff;
   logic                done_ff, done_in;
   logic [BG_LO_BITS+RATIO_BITS-1:0] pp_lo_ff;
   logic [BG_HI_BITS+RATIO_BITS-1:0] pp_hi_ff;
   logic [PROD_BITS-1:0] prod;
   logic [PROD_BITS-1:0] lhs;
   logic                 exceed;
   logic                 s3_emit;
   logic                 s3_found;
   logic [IDX_BITS-1:0]  s3_onset;

   // output register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         win_len_ff <= WINDOW_LENGTH_RESET;
         ratio_ff   <= POWER_RATIO_RESET;
         pre_ff     <= PRE_ONSET_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WINDOW_LENGTH: win_len_ff <= csr_wdata[WIN_BITS-1:0];
            CSR_POWER_RATIO:   ratio_ff   <= csr_wdata[RATIO_BITS-1:0];
            CSR_PRE_ONSET:     pre_ff     <= csr_wdata[PRE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // pipeline moves unless a result is blocked behind a full output register
   assign adv       = !(rsp_valid_ff && !rsp_ready && s3_valid_ff && s3_emit);
   assign req_ready = adv;
   assign accept    = req_valid && adv;

   // window clamp and front state next values
   always_comb begin
      if (win_len_ff == '0) begin
         win_eff = WIN_BITS'(1);
      end else if (win_len_ff > WIN_BITS'(WINDOW_MAX)) begin
         win_eff = WIN_BITS'(WINDOW_MAX);
      end else begin
         win_eff = win_len_ff;
      end
      win_in   = (count_ff == '0) ? win_eff : win_ff;
      fill_end = ({1'b0, count_ff} + (IDX_BITS+1)'(1)) >= (IDX_BITS+1)'(win_in);
      ptr_inc  = {2'b00, ptr_ff} + (WIN_BITS+1)'(1);
      count_in = (count_ff == '1) ? count_ff : count_ff + IDX_BITS'(1);
      ptr_in   = (ptr_inc >= {1'b0, win_in}) ? '0 : ptr_inc[PTR_BITS-1:0];
      fill_in  = fill_ff && !fill_end;
      if (req_data.last) begin
         count_in = '0;
         ptr_in   = '0;
         fill_in  = 1'b1;
      end
   end

   // front state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ptr_ff   <= '0;
         win_ff   <= WIN_BITS'(1);
         fill_ff  <= 1'b1;
      end else if (accept) begin
         count_ff <= count_in;
         ptr_ff   <= ptr_in;
         win_ff   <= win_in;
         fill_ff  <= fill_in;
      end
   end

   // sample ring: oldest sample read out as the new one replaces it
   sroc_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (WINDOW_MAX)
   ) u_ring (
      .clock (clock),
      .we    (accept),
      .waddr (ptr_ff),
      .wdata (req_data.sample),
      .re    (accept),
      .raddr (ptr_ff),
      .rdata (ring_rdata)
   );

   // stage 1 registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sample_ff <= req_data.sample;
         s1_last_ff   <= req_data.last;
         s1_fill_ff   <= fill_ff;
         s1_fend_ff   <= fill_end;
         s1_idx_ff    <= count_ff;
      end
   end

   // squares of new and outgoing samples
   assign sq_full  = s1_sample_ff * s1_sample_ff;
   assign osq_full = $signed(ring_rdata) * $signed(ring_rdata);

   // stage 2 registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && s1_valid_ff) begin
         s2_sq_ff   <= sq_full[SQ_BITS-1:0];
         s2_osq_ff  <= osq_full[SQ_BITS-1:0];
         s2_last_ff <= s1_last_ff;
         s2_fill_ff <= s1_fill_ff;
         s2_fend_ff <= s1_fend_ff;
         s2_idx_ff  <= s1_idx_ff;
      end
   end

   // sliding sum update, clamped at zero; background captured at window end
   always_comb begin
      acc = {1'b0, sum_ff} + {{(SUM_BITS-SQ_BITS+1){1'b0}}, s2_sq_ff};
      if (s2_fill_ff) begin
         sum_new = acc[SUM_BITS-1:0];
      end else if (acc >= {{(SUM_BITS-SQ_BITS+1){1'b0}}, s2_osq_ff}) begin
         sum_new = SUM_BITS'(acc - {{(SUM_BITS-SQ_BITS+1){1'b0}}, s2_osq_ff});
      end else begin
         sum_new = '0;
      end
      sum_in = s2_last_ff ? '0 : sum_new;
      bg_in  = bg_ff;
      if (s2_fill_ff && s2_fend_ff) begin
         bg_in = (sum_new == '0) ? SUM_BITS'(1) : sum_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         sum_ff      <= '0;
         bg_ff       <= '0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
         if (s2_valid_ff) begin
            sum_ff <= sum_in;
            bg_ff  <= bg_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv && s2_valid_ff) begin
         s3_sum_ff  <= sum_new;
         s3_last_ff <= s2_last_ff;
         s3_fill_ff <= s2_fill_ff;
         s3_idx_ff  <= s2_idx_ff;
      end
   end

   // background times ratio as two registered partial products
   always_ff @(posedge clock) begin
      pp_lo_ff <= bg_ff[BG_LO_BITS-1:0] * ratio_ff;
      pp_hi_ff <= bg_ff[SUM_BITS-1:BG_LO_BITS] * ratio_ff;
   end

   // threshold compare and result selection
   always_comb begin
      prod = {pp_hi_ff, {BG_LO_BITS{1'b0}}}
           + {{(PROD_BITS-BG_LO_BITS-RATIO_BITS){1'b0}}, pp_lo_ff};
      lhs  = {{(PROD_BITS-SUM_BITS-8){1'b0}}, s3_sum_ff, 8'd0};
      exceed = lhs > prod;
      s3_onset = (s3_idx_ff >= IDX_BITS'(pre_ff)) ? s3_idx_ff - IDX_BITS'(pre_ff) : '0;
      s3_found = 1'b0;
      if (s3_fill_ff) begin
         s3_emit = s3_last_ff;
      end else if (done_ff) begin
         s3_emit = 1'b0;
      end else if (exceed) begin
         s3_emit  = 1'b1;
         s3_found = 1'b1;
      end else begin
         s3_emit = s3_last_ff;
      end
      done_in = done_ff;
      if (s3_last_ff) begin
         done_in = 1'b0;
      end else if (!s3_fill_ff && exceed) begin
         done_in = 1'b1;
      end
   end

   // onset flag and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv && s3_valid_ff) begin
            done_ff <= done_in;
         end
         if (adv && s3_valid_ff && s3_emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv && s3_valid_ff && s3_emit) begin
         rsp_data_ff.found       <= s3_found;
         rsp_data_ff.onset_index <= s3_found ? s3_onset : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a not-found beat always carries index zero
   a_notfound_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.found) |-> (rsp_data.onset_index == '0))
      else $error("not-found result with nonzero index");

   // the final sample of a buffer restarts the front state
   a_buffer_restart: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.last) |=>
         (count_ff == '0 && ptr_ff == '0 && fill_ff))
      else $error("buffer state not restarted after last sample");

   // the ring pointer stays inside the latched window
   a_ptr_in_window: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, ptr_ff} < win_ff))
      else $error("ring pointer outside latched window");

endmodule

>>> hw/rtl/sroc_ram.sv
// sroc_ram: generic simple dual port ram, one write and one registered read port
// read returns the old contents when the same address is written in that cycle
// no dependencies
module sroc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // storage array with read-first registered output
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> tb/sliding_rms_onset_detector_core_test.sv
// sliding_rms_onset_detector_core_test: self-checking bench for the onset detector core
// streams audio buffers with bursty input and stalling output, predicts each result beat
// depends on sroc_pkg and sliding_rms_onset_detector_core
module sliding_rms_onset_detector_core_test;

   import sroc_pkg::*;

   typedef enum logic [1:0] {BG_FILL, WATCH, HOLD} watch_stage_type;

   // tracks the detector state per accepted beat and holds the onsets still owed
   class onset_scoreboard_type;
      logic [WIN_BITS-1:0]           window_length;
      logic [RATIO_BITS-1:0]         power_ratio;
      logic [PRE_BITS-1:0]           pre_onset;
      logic signed [SAMPLE_BITS-1:0] ring [WINDOW_MAX];
      int unsigned                   ring_ptr;
      int unsigned                   window_latched;
      logic [63:0]                   window_sum;
      logic [63:0]                   background;
      logic [31:0]                   sample_index;
      watch_stage_type               stage;
      rsp_type                       expected_onsets [$];
      int                            mismatches;
      int                            samples_seen;

      function new();
         window_length = WINDOW_LENGTH_RESET;
         power_ratio   = POWER_RATIO_RESET;
         pre_onset     = PRE_ONSET_RESET;
         mismatches    = 0;
         samples_seen  = 0;
         start_buffer();
      endfunction

      function void start_buffer();
         ring_ptr       = 0;
         window_sum     = '0;
         background     = '0;
         sample_index   = '0;
         stage          = BG_FILL;
         window_latched = 1;
      endfunction

      task report(input string what);
         mismatches++;
         $display("mismatch at %0t: %s", $time, what);
      endtask

      task write_register(input logic [CSR_INDEX_BITS-1:0] index,
                          input logic [CSR_DATA_BITS-1:0] data);
         case (index)
            CSR_WINDOW_LENGTH: window_length = data[WIN_BITS-1:0];
            CSR_POWER_RATIO:   power_ratio = data[RATIO_BITS-1:0];
            CSR_PRE_ONSET:     pre_onset = data[PRE_BITS-1:0];
            default: ;
         endcase
      endtask

      // squared compare: sum * 256 > background * ratio, wide enough to never wrap
      function bit above_threshold();
         logic [71:0] lhs;
         logic [71:0] rhs;
         lhs = {8'b0, window_sum} << 8;
         rhs = 72'(background) * 72'(power_ratio);
         return lhs > rhs;
      endfunction

      function void owe_result(input logic found, input logic [31:0] index);
         rsp_type e;
         e.found = found;
         e.onset_index = index;
         expected_onsets.insert(expected_onsets.size(), e);
      endfunction

      task note_sample(input req_type beat);
         longint      s;
         longint      old;
         logic [63:0] sq;
         logic [63:0] osq;
         logic [63:0] acc;
         logic [31:0] idx;
         int unsigned slot;
         s = longint'(beat.sample);
         sq = s * s;
         idx = sample_index;
         samples_seen++;
         if (sample_index != '1) sample_index++;
         case (stage)
            BG_FILL: begin
               if (idx == 0) begin
                  if (window_length == 0) window_latched = 1;
                  else if (window_length > WINDOW_MAX) window_latched = WINDOW_MAX;
                  else window_latched = 32'(window_length);
               end
               slot = ring_ptr;
               ring[slot] = beat.sample;
               slot++;
               ring_ptr = (slot >= window_latched) ? 0 : slot;
               window_sum += sq;
               if (64'(idx) + 1 >= 64'(window_latched)) begin
                  background = (window_sum == 0) ? 64'd1 : window_sum;
                  stage = WATCH;
               end
               if (beat.last) owe_result(1'b0, '0);
            end
            WATCH: begin
               // slide the window: add the new square, drop the oldest one
               slot = ring_ptr;
               old = longint'(ring[slot]);
               osq = old * old;
               acc = window_sum + sq;
               ring[slot] = beat.sample;
               slot++;
               ring_ptr = (slot >= window_latched) ? 0 : slot;
               window_sum = (acc >= osq) ? acc - osq : '0;
               if (above_threshold()) begin
                  owe_result(1'b1, (idx >= 32'(pre_onset)) ? idx - 32'(pre_onset) : '0);
                  stage = HOLD;
               end else if (beat.last) begin
                  owe_result(1'b0, '0);
               end
            end
            default: ;
         endcase
         if (beat.last) start_buffer();
      endtask

      task check_result(input rsp_type got);
         rsp_type want;
         if (expected_onsets.size() == 0) begin
            report($sformatf("unexpected result found=%0b index=%0d",
                             got.found, got.onset_index));
         end else begin
            want = expected_onsets.pop_front();
            if (got.found !== want.found)
               report($sformatf("found got %0b want %0b", got.found, want.found));
            if (got.onset_index !== want.onset_index)
               report($sformatf("onset_index got %0d want %0d",
                                got.onset_index, want.onset_index));
         end
      endtask
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   req_type                   req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_WINDOW_LENGTH;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   onset_scoreboard_type onsets = new();

   int burst_left = 0;
   int send_pace = 1;
   int cur_window = 441;
   int recv_tick = 0;
   int recv_mode = 0;
   int stall_left = 0;
   int nbuf;

   sliding_rms_onset_detector_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // hard stop in case the design hangs
   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

   // result-side stall pattern: calm, occasional and heavy stretches
   always @(posedge clock) begin
      recv_tick++;
      if (recv_tick % 300 == 0) recv_mode = $urandom_range(0, 2);
      if (stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (recv_mode == 1 && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 6);
         else if (recv_mode == 2 && $urandom_range(0, 1) == 0)
            stall_left = $urandom_range(1, 20);
      end
   end

   // watch register writes and both beat channels in edge order
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) onsets.write_register(csr_index, csr_wdata);
         if (req_valid && req_ready) onsets.note_sample(req_data);
         if (rsp_valid && rsp_ready) onsets.check_result(rsp_data);
      end
   end

   // one input beat, with a random gap at the start of each burst
   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic l);
      req_type beat;
      int      gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         case (send_pace)
            0: gap = 0;
            1: gap = $urandom_range(0, 3);
            default: gap = $urandom_range(1, 12);
         endcase
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      beat.sample = s;
      beat.last = l;
      req_valid <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (req_ready !== 1'b1);
   endtask

   // stop sending, collect every owed result, then let the pipeline empty
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (onsets.expected_onsets.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic configure(input int w, input logic [RATIO_BITS-1:0] ratio,
                            input logic [PRE_BITS-1:0] pre);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_WINDOW_LENGTH;
      csr_wdata <= CSR_DATA_BITS'(w);
      @(posedge clock);
      csr_index <= CSR_POWER_RATIO;
      csr_wdata <= CSR_DATA_BITS'(ratio);
      @(posedge clock);
      csr_index <= CSR_PRE_ONSET;
      csr_wdata <= CSR_DATA_BITS'(pre);
      @(posedge clock);
      csr_we <= 1'b0;
      cur_window = (w == 0) ? 1 : (w > WINDOW_MAX) ? WINDOW_MAX : w;
   endtask

   task automatic new_settings(input int force_window);
      int                    w;
      logic [RATIO_BITS-1:0] ratio;
      logic [PRE_BITS-1:0]   pre;
      if (force_window >= 0) begin
         w = force_window;
      end else begin
         case ($urandom_range(0, 9))
            0: w = 0;
            1, 2: w = 1;
            default: w = $urandom_range(2, 40);
         endcase
      end
      case ($urandom_range(0, 7))
         0: ratio = '0;
         1: ratio = '1;
         2, 3, 4: ratio = RATIO_BITS'($urandom_range(256, 4096));
         5: ratio = RATIO_BITS'($urandom_range(1, 255));
         default: ratio = RATIO_BITS'($urandom());
      endcase
      case ($urandom_range(0, 7))
         0: pre = '0;
         1: pre = '1;
         2, 3, 4, 5: pre = PRE_BITS'($urandom_range(0, 8));
         default: pre = PRE_BITS'($urandom());
      endcase
      configure(w, ratio, pre);
   endtask

   function automatic int pick_amplitude();
      case ($urandom_range(0, 4))
         0: return 0;
         1: return 3;
         2: return 90;
         3: return 2000;
         default: return 32767;
      endcase
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] spread(input int amp);
      int v;
      v = int'($urandom_range(0, 2 * amp)) - amp;
      return v[SAMPLE_BITS-1:0];
   endfunction

   // quiet background window, then a louder tail; some buffers end early or are noise
   task automatic send_buffer(input bit split);
      int kind;
      int len;
      int loud_at;
      int quiet_amp;
      int loud_amp;
      int cut;
      logic signed [SAMPLE_BITS-1:0] s;
      kind = $urandom_range(0, 9);
      quiet_amp = pick_amplitude();
      loud_amp = pick_amplitude();
      if (kind <= 1) len = $urandom_range(1, cur_window);
      else len = cur_window + $urandom_range(1, 24);
      loud_at = cur_window + $urandom_range(0, 20);
      cut = (split && len > 1) ? $urandom_range(0, len - 2) : -1;
      for (int i = 0; i < len; i++) begin
         if (kind == 2) s = SAMPLE_BITS'($urandom());
         else if (i < loud_at) s = spread(quiet_amp);
         else s = spread(loud_amp);
         send_sample(s, i == len - 1);
         // settings change in the middle of a buffer
         if (i == cut) begin
            drain_results();
            new_settings(-1);
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // short buffers, exact-window buffer, onset on the final beat, beats after onset
      configure(2, 24'd256, 16'd0);
      send_sample(16'sd32767, 1'b1);
      send_sample(16'sd1, 1'b0);
      send_sample(16'sd1, 1'b1);
      send_sample(16'sd1, 1'b0);
      send_sample(16'sd1, 1'b0);
      send_sample(16'sd2, 1'b1);
      send_sample(16'sd0, 1'b0);
      send_sample(16'sd0, 1'b0);
      send_sample(-16'sd32768, 1'b0);
      send_sample(16'sd5, 1'b0);
      send_sample(-16'sd1, 1'b1);
      drain_results();

      // zero window acts as one, zero ratio, backoff clamped at zero
      configure(0, 24'd0, 16'hFFFF);
      send_sample(-16'sd1, 1'b0);
      send_sample(16'sd0, 1'b0);
      send_sample(16'sd7, 1'b1);
      drain_results();

      // full-scale ratio against a floored background
      configure(1, 24'hFFFFFF, 16'd1);
      send_sample(16'sd0, 1'b0);
      send_sample(-16'sd32768, 1'b0);
      send_sample(16'sd32767, 1'b1);
      drain_results();

      // window rewritten inside a buffer only applies to the next one
      configure(3, 24'd512, 16'd0);
      send_sample(16'sd100, 1'b0);
      send_sample(-16'sd100, 1'b0);
      drain_results();
      configure(1, 24'd512, 16'd0);
      send_sample(16'sd100, 1'b0);
      send_sample(16'sd3000, 1'b0);
      send_sample(16'sd5, 1'b1);
      send_sample(16'sd4, 1'b0);
      send_sample(16'sd4000, 1'b1);
      drain_results();

      // random phases with small windows
      while (onsets.samples_seen < 700) begin
         send_pace = $urandom_range(0, 2);
         new_settings(-1);
         nbuf = (cur_window <= 2) ? $urandom_range(4, 16) : $urandom_range(1, 4);
         repeat (nbuf) send_buffer($urandom_range(0, 7) == 0);
         drain_results();
      end

      // oversize window value acts as the largest window
      send_pace = 1;
      new_settings(2047);
      send_buffer(1'b0);
      drain_results();

      if (onsets.mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
